FILE: rtl/msct_pkg.sv
`default_nettype none

package msct_pkg;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int ID_W    = 16;
    localparam int KEY_W   = 32;
    localparam int LIVE_W  = 5;
    localparam int ENTRY_W = 2 * ID_W;
    localparam int DIV_CNT_W = $clog2(KEY_W + 1);

    // Request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_REGISTER   = 2'd0,
        FUNC_UNREGISTER = 2'd1,
        FUNC_SELECT     = 2'd2,
        FUNC_QUERY      = 2'd3
    } func_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_ADDR,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DIV_WAIT,
        ST_SEL_CAP,
        ST_RESP
    } state_t;

    // Table read address source
    typedef enum logic [1:0] {
        RD_IDX,
        RD_NEXT,
        RD_REM
    } rd_sel_t;

    // Table write kind
    typedef enum logic [1:0] {
        WR_NONE,
        WR_UPDATE,
        WR_APPEND,
        WR_SHIFT
    } wr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    latch_in;
        logic    idx_inc;
        logic    rd_en;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    div_start;
        logic    set_found;
        logic    set_dropped;
        logic    sel_capture;
        logic    res_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        func_t func;
        logic  at_end;
        logic  next_at_end;
        logic  hit;
        logic  full;
        logic  empty;
        logic  div_done;
        logic  out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/msct_div.sv
`default_nettype none

module msct_div #(
    parameter int CNT_W = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [msct_pkg::KEY_W-1:0]  dividend,
    input  wire logic [CNT_W-1:0]            divisor,
    output logic                             done,
    output logic [CNT_W-1:0]                 rem
);
    import msct_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [KEY_W-1:0]     shift_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     div_reg;

    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;
    logic [CNT_W-1:0]     rem_next;

    // One restoring step: bring in the next key bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, shift_reg[KEY_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = diff[CNT_W-1:0];
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= DIV_CNT_W'(KEY_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[KEY_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/msct_ctrl.sv
`default_nettype none

module msct_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire msct_pkg::status_t status,
    output msct_pkg::cmd_t         cmd
);
    import msct_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '{
            latch_in:    1'b0,
            idx_inc:     1'b0,
            rd_en:       1'b0,
            rd_sel:      RD_IDX,
            wr_sel:      WR_NONE,
            cnt_inc:     1'b0,
            cnt_dec:     1'b0,
            div_start:   1'b0,
            set_found:   1'b0,
            set_dropped: 1'b0,
            sel_capture: 1'b0,
            res_load:    1'b0
        };

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                if (status.func == FUNC_SELECT)
                begin
                    if (status.empty)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV_WAIT;
                    end
                end
                else
                begin
                    state_next = ST_SCAN_ADDR;
                end
            end

            // Fetch the next live entry, or handle a miss at the end
            ST_SCAN_ADDR:
            begin
                if (status.at_end)
                begin
                    if (status.func == FUNC_REGISTER)
                    begin
                        if (status.full)
                        begin
                            cmd.set_dropped = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_sel  = WR_APPEND;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    state_next = ST_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK:
            begin
                if (status.hit)
                begin
                    cmd.set_found = 1'b1;
                    case (status.func)
                        FUNC_REGISTER:
                        begin
                            cmd.wr_sel = WR_UPDATE;
                            state_next = ST_RESP;
                        end
                        FUNC_UNREGISTER:
                        begin
                            state_next = ST_SHIFT_RD;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_ADDR;
                end
            end

            // Close the gap: move entry idx+1 down to idx
            ST_SHIFT_RD:
            begin
                if (status.next_at_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                cmd.wr_sel  = WR_SHIFT;
                cmd.idx_inc = 1'b1;
                state_next  = ST_SHIFT_RD;
            end

            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_REM;
                    state_next = ST_SEL_CAP;
                end
            end

            ST_SEL_CAP:
            begin
                cmd.sel_capture = 1'b1;
                cmd.set_found   = 1'b1;
                state_next      = ST_RESP;
            end

            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/msct_dp.sv
`default_nettype none

module msct_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire msct_pkg::cmd_t               cmd,
    output msct_pkg::status_t                 status,
    input  wire logic [msct_pkg::FUNC_W-1:0]  func,
    input  wire logic [msct_pkg::ID_W-1:0]    conn_id,
    input  wire logic [msct_pkg::ID_W-1:0]    handler_id,
    input  wire logic [msct_pkg::KEY_W-1:0]   select_key,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              found,
    output logic                              dropped,
    output logic [msct_pkg::ID_W-1:0]         out_conn,
    output logic [msct_pkg::ID_W-1:0]         out_handler,
    output logic [msct_pkg::LIVE_W-1:0]       live_count
);
    import msct_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    // Latched request
    func_t              func_reg;
    logic [ID_W-1:0]    conn_reg;
    logic [ID_W-1:0]    handler_reg;
    logic [KEY_W-1:0]   key_reg;

    // Table bookkeeping
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_plus;

    // Result being built
    logic               found_flag_reg;
    logic               dropped_flag_reg;
    logic [ID_W-1:0]    sel_conn_reg;
    logic [ID_W-1:0]    sel_handler_reg;

    // Output register
    logic               out_valid_reg;
    logic               found_reg;
    logic               dropped_reg;
    logic [ID_W-1:0]    out_conn_reg;
    logic [ID_W-1:0]    out_handler_reg;
    logic [LIVE_W-1:0]  live_count_reg;

    // Table memory
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               we;

    // Remainder unit
    logic               div_done;
    logic [CW-1:0]      div_rem;

    msct_div #(
        .CNT_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (key_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign idx_plus = idx_reg + 1'b1;

    // Read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:  raddr = idx_reg[AW-1:0];
            RD_NEXT: raddr = idx_plus[AW-1:0];
            RD_REM:  raddr = div_rem[AW-1:0];
            default: raddr = idx_reg[AW-1:0];
        endcase
    end

    // Write port
    always_comb
    begin
        we    = 1'b1;
        waddr = idx_reg[AW-1:0];
        wdata = {conn_reg, handler_reg};
        case (cmd.wr_sel)
            WR_UPDATE: waddr = idx_reg[AW-1:0];
            WR_APPEND: waddr = count_reg[AW-1:0];
            WR_SHIFT:  wdata = rdata_reg;
            WR_NONE:   we    = 1'b0;
            default:   we    = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Status to controller
    always_comb
    begin
        status.func        = func_reg;
        status.at_end      = (idx_reg == count_reg);
        status.next_at_end = ({1'b0, idx_reg} + 1'b1) >= {1'b0, count_reg};
        status.hit         = (rdata_reg[ENTRY_W-1 -: ID_W] == conn_reg);
        status.full        = (count_reg == CW'(TABLE_DEPTH));
        status.empty       = (count_reg == '0);
        status.div_done    = div_done;
        status.out_free    = !out_valid_reg || out_ready;
    end

    // Control state: live count, scan index, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.latch_in)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus;
            end

            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request latch and result build-up
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg         <= func_t'(func);
            conn_reg         <= conn_id;
            handler_reg      <= handler_id;
            key_reg          <= select_key;
            found_flag_reg   <= 1'b0;
            dropped_flag_reg <= 1'b0;
            sel_conn_reg     <= '0;
            sel_handler_reg  <= '0;
        end
        else
        begin
            if (cmd.set_found)
            begin
                found_flag_reg <= 1'b1;
            end
            if (cmd.set_dropped)
            begin
                dropped_flag_reg <= 1'b1;
            end
            if (cmd.sel_capture)
            begin
                sel_conn_reg    <= rdata_reg[ENTRY_W-1 -: ID_W];
                sel_handler_reg <= rdata_reg[ID_W-1:0];
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            found_reg       <= found_flag_reg;
            dropped_reg     <= dropped_flag_reg;
            out_conn_reg    <= sel_conn_reg;
            out_handler_reg <= sel_handler_reg;
            live_count_reg  <= LIVE_W'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign dropped     = dropped_reg;
    assign out_conn    = out_conn_reg;
    assign out_handler = out_handler_reg;
    assign live_count  = live_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("live count above table depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("scan index past live count");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_APPEND) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow the table");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && dropped_reg))
        else $error("result both found and dropped");
`endif

endmodule

`default_nettype wire

FILE: rtl/modulo_select_connection_table.sv
`default_nettype none

// Ordered table of up to TABLE_DEPTH connections (connection id, handler id),
// one request at a time with one result per request. Register updates a
// present id or appends a new one (dropped when full); unregister removes an
// id and moves later entries down; select returns the entry at key modulo the
// live count; query reports presence. Register, unregister and query time
// grows with the number of live entries, set by the linear scan and entry
// move through the one read port and one write port of the table memory;
// select time is set by the remainder unit retiring one key bit per cycle,
// and an empty table skips that unit. A finished result sits in the output
// register until taken; the next request is accepted meanwhile, and its
// result waits in the controller until the output register is free.
module modulo_select_connection_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [msct_pkg::FUNC_W-1:0]  func,
    input  wire logic [msct_pkg::ID_W-1:0]    conn_id,
    input  wire logic [msct_pkg::ID_W-1:0]    handler_id,
    input  wire logic [msct_pkg::KEY_W-1:0]   select_key,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              found,
    output logic                              dropped,
    output logic [msct_pkg::ID_W-1:0]         out_conn,
    output logic [msct_pkg::ID_W-1:0]         out_handler,
    output logic [msct_pkg::LIVE_W-1:0]       live_count
);
    import msct_pkg::*;

    cmd_t    cmd;
    status_t status;

    msct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    msct_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (func),
        .conn_id     (conn_id),
        .handler_id  (handler_id),
        .select_key  (select_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .dropped     (dropped),
        .out_conn    (out_conn),
        .out_handler (out_handler),
        .live_count  (live_count)
    );

endmodule

`default_nettype wire
